// ----- design/coxkl_pkg.sv -----
// Package for the Cox KL loss and residual block.
// Types, fixed-point constants and register codes; no dependencies.

package coxkl_pkg;

    localparam int MAX_SUBJECTS = 64;
    localparam int IDX_W        = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SUBJECTS + 1);

    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 64;

    localparam logic REG_KL_WEIGHT  = 1'b0;
    localparam logic REG_LOSS_START = 1'b1;

    // log2(e) and ln(2) in Q.32
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    // 12*2^32 - 8*log2(e) in Q.32: moves eta+8 back to eta with an offset on k
    localparam logic [39:0] EXP_BIAS  = 40'd1968983400;
    // 28*ln(2) in Q.32
    localparam logic signed [39:0] LN_OFS = 40'sd83357245216;

    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [4:0]  EXP_TERMS = 5'd12;
    localparam logic [4:0]  LOG_LAST  = 5'd21;
    localparam logic [4:0]  LOG_FIRST = 5'd3;

    localparam logic [24:0] GAMMA_ONE = 25'd65536;

    typedef struct packed {
        logic signed [19:0] linear_predictor;
        logic               event_flag;
        logic [23:0]        prior_hazard;
        logic               final_subject;
    } t_item;

    typedef struct packed {
        logic signed [23:0] residual;
        logic signed [47:0] loss_total;
        logic               run_end;
    } t_result;

endpackage

// ----- design/cox_kl_loss_and_residual.sv -----
// Cox partial-likelihood loss and working residuals with a KL prior term.
// Uses coxkl_pkg; one module holding stores, sequencer, multiplier and divider.
//
// channel  | handshake                    | payload
// ---------+------------------------------+-------------------
// item in  | start, busy                  | i_item (t_item)
// result   | o_res_strobe (one cycle)     | o_result (t_result)
// config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A subject without the final flag is taken and busy stays low.
// The final beat starts three passes, each a small sequence on one 33x33
// multiplier and one radix-2 divider (32 or 64 steps): exp for every
// subject, the log for every event subject, and the residual pass for
// every subject.
// Reset is synchronous; stores are not cleared. Results cannot be stalled.

module cox_kl_loss_and_residual
    import coxkl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_item              i_item,
    output logic               o_res_strobe,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_A_RD, ST_A_U, ST_A_Y, ST_A_W, ST_A_T0, ST_A_TM, ST_A_TD, ST_A_TW, ST_A_H,
        ST_B_RD, ST_B_S, ST_B_NRM, ST_B_Z, ST_B_ZW, ST_B_Z2, ST_B_Z2R, ST_B_TM,
        ST_B_TD, ST_B_TW, ST_B_PN, ST_B_LN, ST_B_LS, ST_B_NX, ST_B_END,
        ST_C_RD, ST_C_E, ST_C_EW, ST_C_M, ST_C_A, ST_C_H, ST_C_TG, ST_C_TW, ST_C_NX
    } t_state;

    t_state r_state;

    // configuration
    logic [23:0]        r_kl_weight;
    logic signed [47:0] r_loss_start;

    // stores
    logic [19:0] r_pred_mem  [MAX_SUBJECTS];
    logic        r_evt_mem   [MAX_SUBJECTS];
    logic [23:0] r_prior_mem [MAX_SUBJECTS];
    logic [39:0] r_haz_mem   [MAX_SUBJECTS];
    logic [47:0] r_risk_mem  [MAX_SUBJECTS];
    logic [19:0] r_pred_q;
    logic        r_evt_q;
    logic [23:0] r_prior_q;
    logic [39:0] r_haz_q;
    logic [47:0] r_risk_q;

    // sequencer and datapath registers
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_last;
    logic [31:0]        r_frac;
    logic [4:0]         r_kz;
    logic [31:0]        r_w;
    logic [32:0]        r_term;
    logic [33:0]        r_sum;
    logic [4:0]         r_j;
    logic [47:0]        r_risk;
    logic [47:0]        r_nrm;
    logic [5:0]         r_p;
    logic [31:0]        r_t;
    logic [31:0]        r_z2;
    logic [33:0]        r_acc;
    logic signed [39:0] r_ln;
    logic signed [55:0] r_loss;
    logic signed [47:0] r_loss_tot;
    logic [63:0]        r_cum;
    logic [1:0]         r_pp;
    logic [103:0]       r_macc;
    logic [40:0]        r_h16;
    logic               r_out_v;
    t_result            r_out;

    // shared multiplier
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [65:0] r_prod;

    // shared divider
    logic        dv_start;
    logic        dv_half;
    logic [63:0] dv_num;
    logic [63:0] dv_den;
    logic [63:0] r_dv_rem;
    logic [63:0] r_dv_q;
    logic [63:0] r_dv_den;
    logic [6:0]  r_dv_cnt;
    logic [64:0] dv_shift;
    logic [65:0] dv_diff;
    logic        dv_done;

    logic               cfg_we;
    logic               in_acc;
    logic               store_en;
    logic [CNT_W-1:0]   cnt_new;
    logic [CNT_W-1:0]   last_w;
    logic [39:0]        exp_z;
    logic [39:0]        haz_val;
    logic [47:0]        risk_sum;
    logic [47:0]        risk_nz;
    logic [24:0]        den_g;
    logic signed [40:0] loss_v;
    logic signed [40:0] loss_vr;
    logic [103:0]       pp_ext;
    logic [63:0]        h32;
    logic [48:0]        h16;
    logic [40:0]        h16c;
    logic signed [49:0] res_w;
    logic signed [23:0] res_sat;
    logic signed [47:0] loss_sat;
    logic               at_last;

    function automatic logic [39:0] scale_hazard(input logic [33:0] s, input logic [4:0] kz);
        logic [39:0] ext;
        logic [4:0]  sh;
        logic [39:0] half;
        ext  = {6'b0, s};
        sh   = 5'd16 - kz;
        half = 40'd1 << (sh - 5'd1);
        if (kz >= 5'd16) begin
            return ext << (kz - 5'd16);
        end
        return (ext + half) >> sh;
    endfunction

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign busy    = (r_state != ST_IDLE);
    assign in_acc  = start & ~busy;
    assign store_en = in_acc & (r_count < CNT_W'(MAX_SUBJECTS));
    assign cnt_new = store_en ? r_count + 1'b1 : r_count;
    assign last_w  = cnt_new - 1'b1;
    assign at_last = (r_idx == r_last);

    assign o_res_strobe = r_out_v;
    assign o_result     = r_out;

    always_comb begin
        case (paddr[PADDR_W-1])
            REG_KL_WEIGHT:  prdata = {40'b0, r_kl_weight};
            REG_LOSS_START: prdata = {{16{r_loss_start[47]}}, r_loss_start};
            default:        prdata = '0;
        endcase
    end

    // combinational datapath pieces
    assign exp_z    = {3'b0, r_prod[52:16]} + EXP_BIAS;
    assign haz_val  = scale_hazard(r_sum, r_kz);
    assign risk_sum = r_risk + {8'b0, r_haz_q};
    assign risk_nz  = (r_risk_q == 48'd0) ? 48'd1 : r_risk_q;
    assign den_g    = GAMMA_ONE + {1'b0, r_kl_weight};
    assign loss_v   = {{5{r_pred_q[19]}}, r_pred_q, 16'b0} - {r_ln[39], r_ln};
    assign loss_vr  = loss_v + 41'sd32768;

    always_comb begin
        case (r_pp)
            2'd0:    pp_ext = {40'b0, r_prod[63:0]};
            2'd3:    pp_ext = {r_prod[39:0], 64'b0};
            default: pp_ext = {8'b0, r_prod[63:0], 32'b0};
        endcase
    end

    assign h32  = (|r_macc[103:92]) ? '1 : r_macc[91:28];
    assign h16  = {1'b0, h32[63:16]} + {48'b0, h32[15]};
    assign h16c = (h16 > 49'h100_0000_0000) ? 41'h100_0000_0000 : h16[40:0];
    assign res_w = $signed({16'b0, r_dv_q[33:0]}) - $signed({9'b0, r_h16});

    always_comb begin
        if (res_w > 50'sd8388607) begin
            res_sat = 24'sh7FFFFF;
        end else if (res_w < -50'sd8388608) begin
            res_sat = -24'sh800000;
        end else begin
            res_sat = res_w[23:0];
        end
    end

    always_comb begin
        if (!r_loss[55] && (|r_loss[54:47])) begin
            loss_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (r_loss[55] && !(&r_loss[54:47])) begin
            loss_sat = 48'sh8000_0000_0000;
        end else begin
            loss_sat = r_loss[47:0];
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_A_U: begin
                mul_a = {13'b0, ~r_pred_q[19], r_pred_q[18:0]};
                mul_b = LOG2E_Q32;
            end
            ST_A_W: begin
                mul_a = {1'b0, r_frac};
                mul_b = {1'b0, LN2_Q32};
            end
            ST_A_TM: begin
                mul_a = r_term;
                mul_b = {1'b0, r_w};
            end
            ST_B_Z2: begin
                mul_a = {1'b0, r_t};
                mul_b = {1'b0, r_t};
            end
            ST_B_TM: begin
                mul_a = {1'b0, r_t};
                mul_b = {1'b0, r_z2};
            end
            ST_B_PN: begin
                mul_a = {27'b0, r_p};
                mul_b = {1'b0, LN2_Q32};
            end
            ST_C_M: begin
                mul_a = r_pp[1] ? {1'b0, r_cum[63:32]} : {1'b0, r_cum[31:0]};
                mul_b = r_pp[0] ? {25'b0, r_haz_q[39:32]} : {1'b0, r_haz_q[31:0]};
            end
            ST_C_H: begin
                mul_a = {9'b0, r_kl_weight};
                mul_b = {9'b0, r_prior_q};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {33'b0, mul_a} * {33'b0, mul_b};
    end

    // divider operand select
    always_comb begin
        dv_start = 1'b0;
        dv_half  = 1'b0;
        dv_num   = '0;
        dv_den   = '0;
        case (r_state)
            ST_A_TD, ST_B_TD: begin
                dv_start = 1'b1;
                dv_half  = 1'b1;
                dv_num   = {32'b0, r_prod[63:32]};
                dv_den   = {59'b0, r_j};
            end
            ST_B_Z: begin
                dv_start = 1'b1;
                dv_num   = {r_nrm[46:15], 32'b0};
                dv_den   = {30'b0, 2'b10, r_nrm[46:15]};
            end
            ST_C_E: begin
                dv_start = r_evt_q;
                dv_num   = (64'd1 << 60) + {17'b0, risk_nz[47:1]};
                dv_den   = {16'b0, risk_nz};
            end
            ST_C_TG: begin
                dv_start = 1'b1;
                dv_num   = {31'b0, r_evt_q, 32'b0} + {16'b0, r_prod[47:0]}
                         + {40'b0, den_g[24:1]};
                dv_den   = {39'b0, den_g};
            end
            default: begin
                dv_start = 1'b0;
            end
        endcase
    end

    assign dv_shift = {r_dv_rem, r_dv_q[63]};
    assign dv_diff  = {1'b0, dv_shift} - {2'b0, r_dv_den};
    assign dv_done  = (r_dv_cnt == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (dv_start) begin
            r_dv_rem <= '0;
            r_dv_q   <= dv_half ? {dv_num[31:0], 32'b0} : dv_num;
            r_dv_den <= dv_den;
            r_dv_cnt <= dv_half ? 7'd32 : 7'd64;
        end else if (!dv_done) begin
            r_dv_rem <= dv_diff[65] ? dv_shift[63:0] : dv_diff[63:0];
            r_dv_q   <= {r_dv_q[62:0], ~dv_diff[65]};
            r_dv_cnt <= r_dv_cnt - 1'b1;
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_pred_mem[r_count[IDX_W-1:0]]  <= i_item.linear_predictor;
            r_evt_mem[r_count[IDX_W-1:0]]   <= i_item.event_flag;
            r_prior_mem[r_count[IDX_W-1:0]] <= i_item.prior_hazard;
        end
        if (r_state == ST_A_H) begin
            r_haz_mem[r_idx] <= haz_val;
        end
        if (r_state == ST_B_S) begin
            r_risk_mem[r_idx] <= risk_sum;
        end
        r_pred_q  <= r_pred_mem[r_idx];
        r_evt_q   <= r_evt_mem[r_idx];
        r_prior_q <= r_prior_mem[r_idx];
        r_haz_q   <= r_haz_mem[r_idx];
        r_risk_q  <= r_risk_mem[r_idx];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kl_weight  <= '0;
            r_loss_start <= '0;
        end else if (cfg_we) begin
            case (paddr[PADDR_W-1])
                REG_KL_WEIGHT:  r_kl_weight  <= pwdata[23:0];
                REG_LOSS_START: r_loss_start <= pwdata[47:0];
                default:        r_kl_weight  <= r_kl_weight;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_last     <= '0;
            r_loss_tot <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_count <= cnt_new;
                        if (i_item.final_subject) begin
                            r_last  <= last_w[IDX_W-1:0];
                            r_idx   <= '0;
                            r_state <= ST_A_RD;
                        end
                    end
                end
                // pass one: hazards
                ST_A_RD: r_state <= ST_A_U;
                ST_A_U:  r_state <= ST_A_Y;
                ST_A_Y: begin
                    r_frac  <= exp_z[31:0];
                    r_kz    <= exp_z[36:32];
                    r_state <= ST_A_W;
                end
                ST_A_W: r_state <= ST_A_T0;
                ST_A_T0: begin
                    r_w     <= r_prod[63:32];
                    r_term  <= ONE_Q32;
                    r_sum   <= {1'b0, ONE_Q32};
                    r_j     <= 5'd1;
                    r_state <= ST_A_TM;
                end
                ST_A_TM: r_state <= ST_A_TD;
                ST_A_TD: r_state <= ST_A_TW;
                ST_A_TW: begin
                    if (dv_done) begin
                        r_term <= r_dv_q[32:0];
                        r_sum  <= r_sum + r_dv_q[33:0];
                        if (r_j == EXP_TERMS) begin
                            r_state <= ST_A_H;
                        end else begin
                            r_j     <= r_j + 5'd1;
                            r_state <= ST_A_TM;
                        end
                    end
                end
                ST_A_H: begin
                    if (at_last) begin
                        r_risk  <= '0;
                        r_loss  <= {{8{r_loss_start[47]}}, r_loss_start};
                        r_state <= ST_B_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_A_RD;
                    end
                end
                // pass two: risk sums and loss, last subject first
                ST_B_RD: r_state <= ST_B_S;
                ST_B_S: begin
                    r_risk <= risk_sum;
                    r_nrm  <= (risk_sum == 48'd0) ? 48'd1 : risk_sum;
                    r_p    <= 6'd47;
                    r_state <= r_evt_q ? ST_B_NRM : ST_B_NX;
                end
                ST_B_NRM: begin
                    if (r_nrm[47]) begin
                        r_state <= ST_B_Z;
                    end else begin
                        r_nrm <= {r_nrm[46:0], 1'b0};
                        r_p   <= r_p - 6'd1;
                    end
                end
                ST_B_Z: r_state <= ST_B_ZW;
                ST_B_ZW: begin
                    if (dv_done) begin
                        r_t     <= r_dv_q[31:0];
                        r_acc   <= {2'b0, r_dv_q[31:0]};
                        r_state <= ST_B_Z2;
                    end
                end
                ST_B_Z2: r_state <= ST_B_Z2R;
                ST_B_Z2R: begin
                    r_z2    <= r_prod[63:32];
                    r_j     <= LOG_FIRST;
                    r_state <= ST_B_TM;
                end
                ST_B_TM: r_state <= ST_B_TD;
                ST_B_TD: begin
                    r_t     <= r_prod[63:32];
                    r_state <= ST_B_TW;
                end
                ST_B_TW: begin
                    if (dv_done) begin
                        r_acc <= r_acc + {2'b0, r_dv_q[31:0]};
                        if (r_j == LOG_LAST) begin
                            r_state <= ST_B_PN;
                        end else begin
                            r_j     <= r_j + 5'd2;
                            r_state <= ST_B_TM;
                        end
                    end
                end
                ST_B_PN: r_state <= ST_B_LN;
                ST_B_LN: begin
                    r_ln    <= $signed(r_prod[39:0]) - LN_OFS + $signed({5'b0, r_acc, 1'b0});
                    r_state <= ST_B_LS;
                end
                ST_B_LS: begin
                    r_loss  <= r_loss + {{31{loss_vr[40]}}, loss_vr[40:16]};
                    r_state <= ST_B_NX;
                end
                ST_B_NX: begin
                    if (r_idx == '0) begin
                        r_state <= ST_B_END;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= ST_B_RD;
                    end
                end
                ST_B_END: begin
                    r_loss_tot <= loss_sat;
                    r_cum      <= '0;
                    r_idx      <= '0;
                    r_state    <= ST_C_RD;
                end
                // pass three: residuals in load order
                ST_C_RD: r_state <= ST_C_E;
                ST_C_E: begin
                    r_pp    <= '0;
                    r_macc  <= '0;
                    r_state <= r_evt_q ? ST_C_EW : ST_C_M;
                end
                ST_C_EW: begin
                    if (dv_done) begin
                        r_cum   <= r_cum + r_dv_q;
                        r_state <= ST_C_M;
                    end
                end
                ST_C_M: r_state <= ST_C_A;
                ST_C_A: begin
                    r_macc <= r_macc + pp_ext;
                    if (r_pp == 2'd3) begin
                        r_state <= ST_C_H;
                    end else begin
                        r_pp    <= r_pp + 2'd1;
                        r_state <= ST_C_M;
                    end
                end
                ST_C_H: begin
                    r_h16 <= h16c;
                    if (h32 == 64'd0) begin
                        r_out_v            <= 1'b1;
                        r_out.residual     <= '0;
                        r_out.loss_total   <= at_last ? r_loss_tot : '0;
                        r_out.run_end      <= at_last;
                        r_state            <= ST_C_NX;
                    end else begin
                        r_state <= ST_C_TG;
                    end
                end
                ST_C_TG: r_state <= ST_C_TW;
                ST_C_TW: begin
                    if (dv_done) begin
                        r_out_v          <= 1'b1;
                        r_out.residual   <= res_sat;
                        r_out.loss_total <= at_last ? r_loss_tot : '0;
                        r_out.run_end    <= at_last;
                        r_state          <= ST_C_NX;
                    end
                end
                ST_C_NX: begin
                    if (at_last) begin
                        r_count <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_C_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_res_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> busy)
        else $error("result beat outside a run");

    a_end_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.run_end) |=> !busy)
        else $error("block still busy after last result");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.final_subject) |=> !busy)
        else $error("non-final beat started a run");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_start |-> dv_done)
        else $error("divider restarted while running");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for cox_kl_loss_and_residual: drives subject beats and APB writes,
// predicts residuals and loss bit-exactly from its own fixed-point model, checks each result.
// Depends on coxkl_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
    import coxkl_pkg::*;

    localparam longint LOSS_MAX = 64'sd140737488355327;
    localparam longint LOSS_MIN = -LOSS_MAX - 1;
    localparam logic [63:0] L2E = 64'd6196328019;
    localparam logic [63:0] LN2 = 64'd2977044472;

    typedef struct {
        t_item              it;
        bit                 lit;
        logic signed [23:0] res;
        logic signed [47:0] loss;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_item              i_item = '0;
    logic               o_res_strobe;
    t_result            o_result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predictor state
    logic signed [19:0] eta_mem [MAX_SUBJECTS];
    logic               ev_mem [MAX_SUBJECTS];
    logic [23:0]        prior_mem [MAX_SUBJECTS];
    int                 n_stored = 0;
    logic [23:0]        gamma_q = '0;
    longint             loss_base = 0;

    t_result residual_q [$];
    t_result fresh [$];
    int      errors = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      n_runs = 0;

    t_dir_row dir_rows [0:10] = '{
        '{'{20'sd0, 1'b0, 24'd0, 1'b1}, 1'b1, 24'sd0, 48'sd0},
        '{'{20'sd0, 1'b1, 24'd0, 1'b1}, 1'b1, 24'sd0, 48'sd0},
        '{'{20'sd524287, 1'b1, 24'hFFFFFF, 1'b0}, 1'b0, 24'sd0, 48'sd0},
        '{'{-20'sd524288, 1'b1, 24'd0, 1'b0}, 1'b0, 24'sd0, 48'sd0},
        '{'{20'sd0, 1'b0, 24'hFFFFFF, 1'b1}, 1'b0, 24'sd0, 48'sd0},
        '{'{-20'sd524288, 1'b0, 24'd1, 1'b1}, 1'b1, 24'sd0, 48'sd0},
        '{'{20'sd524287, 1'b1, 24'd0, 1'b1}, 1'b0, 24'sd0, 48'sd0},
        '{'{-20'sd524288, 1'b1, 24'hFFFFFF, 1'b0}, 1'b0, 24'sd0, 48'sd0},
        '{'{20'sd524287, 1'b0, 24'd0, 1'b0}, 1'b0, 24'sd0, 48'sd0},
        '{'{20'sd1, 1'b1, 24'h800000, 1'b0}, 1'b0, 24'sd0, 48'sd0},
        '{'{-20'sd1, 1'b1, 24'h7FFFFF, 1'b1}, 1'b0, 24'sd0, 48'sd0}
    };

    cox_kl_loss_and_residual dut (.*);

    always #10 i_clk = ~i_clk;

    // exp(eta), Q4.16 in, Q12.28 out
    function automatic logic [63:0] hazard_of(logic signed [19:0] eta);
        logic [127:0] u, yb, z, w, s, t;
        int k;
        u = 128'(longint'(eta) + 524288);
        yb = (u * L2E) >> 16;
        z = yb + (128'd12 << 32) - 128'(8 * L2E);
        k = int'(z >> 32) - 12;
        w = ((z & 128'hFFFF_FFFF) * LN2) >> 32;
        s = 128'd1 << 32;
        t = s;
        for (int j = 1; j <= 12; j++) begin
            t = ((t * w) >> 32) / j;
            s = s + t;
        end
        if (k >= 4)
            return 64'(s << (k - 4));
        return 64'((s + (128'd1 << (3 - k))) >> (4 - k));
    endfunction

    // ln of a Q.28 risk sum, signed Q.32
    function automatic longint ln_of(logic [63:0] r);
        int p;
        logic [127:0] m, z, z2, t, acc;
        if (r == 0)
            r = 1;
        p = 63;
        while (!r[p])
            p--;
        m = (p >= 32) ? 128'(r >> (p - 32)) : 128'(r) << (32 - p);
        z = ((m - (128'd1 << 32)) << 32) / (m + (128'd1 << 32));
        z2 = (z * z) >> 32;
        t = z;
        acc = z;
        for (int k = 3; k <= 21; k += 2) begin
            t = (t * z2) >> 32;
            acc = acc + t / k;
        end
        return longint'(p - 28) * longint'(LN2) + longint'(64'(2 * acc));
    endfunction

    // store a subject; on the final one work out the whole run into fresh
    task automatic predict_subject(t_item it);
        logic [63:0]  haz [MAX_SUBJECTS];
        logic [63:0]  risk [MAX_SUBJECTS];
        logic [63:0]  cum, den, num, target, h32, h16, b;
        logic [127:0] pr;
        longint       loss, v, res;
        int           n;
        t_result      r;
        fresh = {};
        if (n_stored < MAX_SUBJECTS) begin
            eta_mem[n_stored] = it.linear_predictor;
            ev_mem[n_stored] = it.event_flag;
            prior_mem[n_stored] = it.prior_hazard;
            n_stored++;
        end
        if (!it.final_subject || n_stored == 0)
            return;
        n = n_stored;
        for (int i = 0; i < n; i++)
            haz[i] = hazard_of(eta_mem[i]);
        risk[n-1] = haz[n-1];
        for (int i = n - 1; i > 0; i--)
            risk[i-1] = risk[i] + haz[i-1];
        loss = loss_base;
        for (int i = 0; i < n; i++) begin
            if (ev_mem[i]) begin
                v = longint'(eta_mem[i]) * 65536 - ln_of(risk[i]);
                b = (64'(v) + (64'd1 << 40) + 64'd32768) >> 16;
                loss = loss + longint'(b) - (64'sd1 <<< 24);
            end
        end
        if (loss > LOSS_MAX) loss = LOSS_MAX;
        if (loss < LOSS_MIN) loss = LOSS_MIN;
        den = 64'd65536 + gamma_q;
        cum = 0;
        for (int i = 0; i < n; i++) begin
            res = 0;
            if (ev_mem[i])
                cum = cum + ((64'd1 << 60) + (risk[i] == 0 ? 0 : risk[i] / 2))
                      / (risk[i] == 0 ? 64'd1 : risk[i]);
            pr = 128'(cum) * 128'(haz[i]);
            h32 = (pr[127:92] != 0) ? '1 : pr[91:28];
            if (h32 != 0) begin
                num = (64'(ev_mem[i]) << 32) + 64'(gamma_q) * 64'(prior_mem[i]);
                target = (num + den / 2) / den;
                h16 = (h32 >> 16) + ((h32 >> 15) & 64'd1);
                if (h16 > (64'd1 << 40)) h16 = 64'd1 << 40;
                res = longint'(target) - longint'(h16);
                if (res > 8388607) res = 8388607;
                if (res < -8388608) res = -8388608;
            end
            r.residual = 24'(res);
            r.loss_total = (i == n - 1) ? 48'(loss) : '0;
            r.run_end = (i == n - 1);
            fresh.push_back(r);
        end
        n_stored = 0;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_res_strobe) begin
            n_results++;
            if (residual_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_result);
            end else begin
                e = residual_q.pop_front();
                if (o_result.residual !== e.residual) begin
                    errors++;
                    $display("%0t: residual exp %0d got %0d", $time, e.residual,
                             o_result.residual);
                end
                if (o_result.loss_total !== e.loss_total) begin
                    errors++;
                    $display("%0t: loss_total exp %0d got %0d", $time, e.loss_total,
                             o_result.loss_total);
                end
                if (o_result.run_end !== e.run_end) begin
                    errors++;
                    $display("%0t: run_end exp %0b got %0b", $time, e.run_end,
                             o_result.run_end);
                end
            end
        end
    end

    task automatic apb_write(logic idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PADDR_W'(idx) << 3; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((idx == REG_KL_WEIGHT && prdata[23:0] !== val[23:0]) ||
            (idx == REG_LOSS_START && prdata[47:0] !== val[47:0])) begin
            errors++;
            $display("%0t: readback reg %0d exp %h got %h", $time, idx, val, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    task automatic set_config(logic [23:0] g, longint ls);
        apb_write(REG_KL_WEIGHT, 64'(g));
        apb_write(REG_LOSS_START, 64'(ls));
        gamma_q = g;
        loss_base = ls;
    endtask

    task automatic send_subject(t_item it, bit lit = 0, logic signed [23:0] lres = 0,
                                logic signed [47:0] lloss = 0);
        int sel, gap;
        sel = $urandom_range(0, 99);
        gap = (sel < 65) ? 0 : (sel < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        n_items++;
        predict_subject(it);
        if (fresh.size() > 0) begin
            n_runs++;
            if (lit)
                residual_q.push_back('{lres, lloss, 1'b1});
            else
                foreach (fresh[i]) residual_q.push_back(fresh[i]);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        wait (residual_q.size() == 0);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic t_item rand_subject(bit fin);
        t_item it;
        case ($urandom_range(0, 7))
            0: it.linear_predictor = -20'sd524288;
            1: it.linear_predictor = 20'sd524287;
            2: it.linear_predictor = 20'($signed($urandom_range(0, 131071)) - 65536);
            default: it.linear_predictor = 20'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: it.prior_hazard = 24'hFFFFFF;
            1: it.prior_hazard = '0;
            default: it.prior_hazard = 24'($urandom);
        endcase
        it.event_flag = 1'($urandom_range(0, 1));
        it.final_subject = fin;
        return it;
    endfunction

    task automatic send_run(int len);
        for (int i = 0; i < len; i++)
            send_subject(rand_subject(i == len - 1));
    endtask

    initial begin
        int len, quota;
        logic [23:0] g_set [5];
        longint      l_set [5];
        g_set = '{24'hFFFFFF, 24'd0, 24'd65536, 24'($urandom), 24'($urandom)};
        l_set = '{LOSS_MAX, LOSS_MIN, 0, longint'($signed(48'($urandom_range(0, 65535)
                  * 64'd4294967296 + $urandom))), -1};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_config(24'd0, 0);
        foreach (dir_rows[i])
            send_subject(dir_rows[i].it, dir_rows[i].lit, dir_rows[i].res, dir_rows[i].loss);
        settle();
        for (int p = 0; p < 5; p++) begin
            set_config(g_set[p], l_set[p]);
            if (p == 3) begin
                send_run(MAX_SUBJECTS);
                send_run(MAX_SUBJECTS + 2);
            end else begin
                quota = n_items + 22;
                while (n_items < quota) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(1, 6);
                    send_run(len);
                end
            end
            settle();
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d subject beats in %0d runs, %0d results, six register settings",
                 n_items, n_runs, n_results);
        $display("including full-store overflow runs and saturating loss limits.");
        if (errors == 0 && residual_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/coxkl_pkg.sv
design/cox_kl_loss_and_residual.sv
bench/tb_top.sv
